/* design/csc_pkg.sv */
// Shared types, constants and arctangent table for the CORDIC sine/cosine pipeline.
package csc_pkg;

    localparam int ITERATIONS   = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int DATA_WIDTH   = 16;
    localparam int ATAN_ENTRIES = 30;
    localparam int SHIFT_W      = $clog2(ATAN_ENTRIES);

    // Q30 angle constants are rounded half up into the angle format.
    localparam int ANGLE_SHIFT = 30 - (ANGLE_WIDTH - 3);
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ROUND_Q30   = 64'd1 << (ANGLE_SHIFT - 1);

    localparam logic signed [ANGLE_WIDTH-1:0] PI_ANGLE =
        ANGLE_WIDTH'((PI_Q30 + ROUND_Q30) >> ANGLE_SHIFT);
    localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI_ANGLE =
        ANGLE_WIDTH'((HALF_PI_Q30 + ROUND_Q30) >> ANGLE_SHIFT);
    localparam logic signed [ANGLE_WIDTH-1:0] NEG_HALF_PI_ANGLE = -HALF_PI_ANGLE;

    // Start vector length 0.60735 in the data format, rounded to nearest.
    localparam longint unsigned X_START_WIDE =
        ((64'd60735 << (DATA_WIDTH - 2)) + 64'd50000) / 64'd100000;
    localparam logic signed [DATA_WIDTH-1:0] X_START = DATA_WIDTH'(X_START_WIDE);

    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
        32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
        32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,       32'd63,
        32'd31,        32'd15,        32'd7,         32'd3,         32'd1
    };

    typedef struct packed {
        logic                           valid;
        logic                           mirror;
        logic signed [DATA_WIDTH-1:0]   x;
        logic signed [DATA_WIDTH-1:0]   y;
        logic signed [ANGLE_WIDTH-1:0]  theta;
    } vec_t;

    function automatic logic signed [ANGLE_WIDTH-1:0] atan_angle(
        input logic [SHIFT_W-1:0] idx
    );
        logic [63:0] wide;
        begin
            wide = ({32'd0, ATAN_Q30[idx]} + ROUND_Q30) >> ANGLE_SHIFT;
            return ANGLE_WIDTH'(wide);
        end
    endfunction

endpackage

/* design/csc_fold.sv */
// Input stage: fold the angle into +-pi/2 and load the start vector.
module csc_fold
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    advance,
    input  logic                                    in_valid,
    input  logic signed [csc_pkg::ANGLE_WIDTH-1:0]  angle,
    output csc_pkg::vec_t                           q
);

    csc_pkg::vec_t vec_reg;
    csc_pkg::vec_t vec_next;

    always_comb
    begin
        vec_next.valid = in_valid;
        vec_next.x     = csc_pkg::X_START;
        vec_next.y     = '0;
        priority if (angle < csc_pkg::NEG_HALF_PI_ANGLE)
        begin
            vec_next.theta  = angle + csc_pkg::PI_ANGLE;
            vec_next.mirror = 1'b1;
        end
        else if (angle > csc_pkg::HALF_PI_ANGLE)
        begin
            vec_next.theta  = angle - csc_pkg::PI_ANGLE;
            vec_next.mirror = 1'b1;
        end
        else
        begin
            vec_next.theta  = angle;
            vec_next.mirror = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg <= '0;
        end
        else if (advance)
        begin
            vec_reg <= vec_next;
        end
    end

    assign q = vec_reg;

endmodule

/* design/csc_cell.sv */
// One CORDIC rotation step with its pipeline register.
module csc_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [csc_pkg::SHIFT_W-1:0]     shift,
    input  csc_pkg::vec_t                   d,
    output csc_pkg::vec_t                   q
);

    csc_pkg::vec_t                          vec_reg;
    csc_pkg::vec_t                          vec_next;
    logic signed [csc_pkg::DATA_WIDTH-1:0]  xs;
    logic signed [csc_pkg::DATA_WIDTH-1:0]  ys;
    logic signed [csc_pkg::ANGLE_WIDTH-1:0] phase;

    assign xs    = d.x >>> shift;
    assign ys    = d.y >>> shift;
    assign phase = csc_pkg::atan_angle(shift);

    always_comb
    begin
        vec_next.valid  = d.valid;
        vec_next.mirror = d.mirror;
        // rotate toward zero residual angle
        if (!d.theta[csc_pkg::ANGLE_WIDTH-1])
        begin
            vec_next.x     = d.x - ys;
            vec_next.y     = d.y + xs;
            vec_next.theta = d.theta - phase;
        end
        else
        begin
            vec_next.x     = d.x + ys;
            vec_next.y     = d.y - xs;
            vec_next.theta = d.theta + phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg <= '0;
        end
        else if (advance)
        begin
            vec_reg <= vec_next;
        end
    end

    assign q = vec_reg;

endmodule

/* design/cordic_sine_cosine.sv */
// Top level: pipelined rotation-mode CORDIC giving sine and cosine of an angle.
//
// Input channel: angle (signed Q2.13 radians, within +-pi) with in_valid / in_stall.
// Output channel: sine and cosine (signed Q1.14) with out_valid / out_stall.
// A word is taken on a rising edge where valid is high and stall is low.
//
// The datapath is a row of identical rotation cells, one per iteration, behind
// a folding stage that maps the angle into +-pi/2, and ahead of an output
// register that negates the results of a folded angle.
// A word passes through the fold register, one register per cell and the output register.
// Throughput: one word per cycle while out_stall does not hold the row; every stage holds one word.
//
// When out_stall is high while a result waits, the whole row holds and
// in_stall rises in the same cycle; it falls as soon as the result is taken.
// Reset clears every stage's valid bit; no word is in flight after reset and
// the block accepts input as soon as rst_n rises.
module cordic_sine_cosine
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [csc_pkg::ANGLE_WIDTH-1:0]  angle,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [csc_pkg::DATA_WIDTH-1:0]   sine,
    output logic signed [csc_pkg::DATA_WIDTH-1:0]   cosine
);

    csc_pkg::vec_t                          chain [csc_pkg::ITERATIONS+1];
    logic                                   advance;
    logic                                   valid_reg;
    logic signed [csc_pkg::DATA_WIDTH-1:0]  sine_reg;
    logic signed [csc_pkg::DATA_WIDTH-1:0]  cosine_reg;
    logic signed [csc_pkg::DATA_WIDTH-1:0]  sine_next;
    logic signed [csc_pkg::DATA_WIDTH-1:0]  cosine_next;

    // hold the row while a finished word waits on a stalled receiver
    assign advance  = !(valid_reg && out_stall);
    assign in_stall = !advance;

    csc_fold u_fold
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid),
        .angle    (angle),
        .q        (chain[0])
    );

    for (genvar i = 0; i < csc_pkg::ITERATIONS; i++)
    begin : g_cell
        csc_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .shift   (csc_pkg::SHIFT_W'(i)),
            .d       (chain[i]),
            .q       (chain[i+1])
        );
    end

    always_comb
    begin
        if (chain[csc_pkg::ITERATIONS].mirror)
        begin
            sine_next   = -chain[csc_pkg::ITERATIONS].y;
            cosine_next = -chain[csc_pkg::ITERATIONS].x;
        end
        else
        begin
            sine_next   = chain[csc_pkg::ITERATIONS].y;
            cosine_next = chain[csc_pkg::ITERATIONS].x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= chain[csc_pkg::ITERATIONS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    assign out_valid = valid_reg;
    assign sine      = sine_reg;
    assign cosine    = cosine_reg;

endmodule
